// ===== src/weighted_sampling_without_replacement_core_macros.svh =====
// assertion helpers, clocked on clk, muted while rst_n is low
`ifndef WEIGHTED_SAMPLING_WITHOUT_REPLACEMENT_CORE_MACROS_SVH
`define WEIGHTED_SAMPLING_WITHOUT_REPLACEMENT_CORE_MACROS_SVH

`define WSWR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define WSWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wswr_pkg.sv =====
`default_nettype none
package wswr_pkg;

  localparam int WEIGHT_W = 16;
  localparam int UNIF_W   = 16;
  localparam int IDX_W    = 6;
  localparam int SS_W     = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_W,
    ST_SORT_J,
    ST_SORT_C,
    ST_SORT_WR,
    ST_MUL,
    ST_WALK_ORD,
    ST_WALK_ENT,
    ST_WALK_EVAL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic draw_start;
    logic refuse;
    logic sort_init;
    logic sort_rd_i;
    logic sort_cap_w;
    logic sort_rd_j;
    logic sort_cmp;
    logic sort_wr;
    logic mul_step;
    logic walk_rd_ord;
    logic walk_eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic draw_ok;
    logic i_last;
    logic j_last;
    logic mul_last;
    logic walk_end;
    logic hit;
  } status_t;

endpackage
`default_nettype wire

// ===== src/wswr_datapath.sv =====
`default_nettype none
module wswr_datapath
  import wswr_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output status_t                  status,
  input  wire logic                cfg_we,
  input  wire logic [SS_W-1:0]     cfg_sample_size,
  input  wire logic [WEIGHT_W-1:0] in_weight,
  input  wire logic [UNIF_W-1:0]   in_uniform,
  input  wire logic                in_last_weight,
  output logic [IDX_W-1:0]         out_selected_index,
  output logic                     out_found,
  output logic                     out_last_draw
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int TW = WEIGHT_BITS + CW;
  localparam int AW = TW + UNIF_W;
  localparam int MW = $clog2(UNIF_W);

  logic [WEIGHT_BITS:0]   entry_mem [MAX_ENTRIES];
  logic [IW-1:0]          order_mem [MAX_ENTRIES];

  logic [CW-1:0]          loaded_r, i_r, j_r, rank_r, k_r;
  logic [SS_W-1:0]        draw_r, ss_r;
  logic [TW-1:0]          total_r, r_r;
  logic                   closed_r;
  logic [WEIGHT_BITS-1:0] wi_r;
  logic [AW-1:0]          acc_r;
  logic [UNIF_W-1:0]      u_r;
  logic [MW-1:0]          m_r;
  logic [IW-1:0]          ord_rd_r;
  logic [WEIGHT_BITS:0]   ent_rd_r;
  logic [IDX_W-1:0]       res_idx_r;
  logic                   res_found_r, res_last_r;

  logic [31:0]            w_ext;
  logic [WEIGHT_BITS-1:0] w_in, ent_w;
  logic                   ent_used;
  logic [TW-1:0]          ent_w_t, w_in_t;
  logic [CW-1:0]          base_loaded;
  logic [TW-1:0]          base_total;
  logic                   room, hit, ahead;
  logic [AW-1:0]          acc_nxt;
  logic [IW-1:0]          ent_addr, mem_waddr;
  logic [WEIGHT_BITS:0]   mem_wdata;
  logic                   mem_we;
  logic [IW+IDX_W-1:0]    idx_ext;
  logic [SS_W-1:0]        draw_inc;

  assign w_ext     = {{(32-WEIGHT_W){1'b0}}, in_weight};
  assign w_in      = w_ext[WEIGHT_BITS-1:0];
  assign w_in_t    = {{(TW-WEIGHT_BITS){1'b0}}, w_in};
  assign ent_w     = ent_rd_r[WEIGHT_BITS-1:0];
  assign ent_used  = ent_rd_r[WEIGHT_BITS];
  assign ent_w_t   = {{(TW-WEIGHT_BITS){1'b0}}, ent_w};

  assign base_loaded = closed_r ? '0 : loaded_r;
  assign base_total  = closed_r ? '0 : total_r;
  assign room        = base_loaded < CW'(MAX_ENTRIES);

  assign hit   = !ent_used && (r_r <= ent_w_t);
  // heavier, or equal and loaded earlier, means it sorts ahead
  assign ahead = (ent_w > wi_r) || ((ent_w == wi_r) && (j_r < i_r));

  assign acc_nxt = {acc_r[AW-2:0], 1'b0} +
                   (u_r[UNIF_W-1] ? {{UNIF_W{1'b0}}, total_r} : '0);

  assign idx_ext  = {{IDX_W{1'b0}}, ord_rd_r};
  assign draw_inc = draw_r + SS_W'(1);

  always_comb begin
    if (cmd.sort_rd_i) begin
      ent_addr = i_r[IW-1:0];
    end else if (cmd.sort_rd_j) begin
      ent_addr = j_r[IW-1:0];
    end else begin
      ent_addr = ord_rd_r;
    end
  end

  assign mem_we    = (cmd.load && room) || (cmd.walk_eval && hit);
  assign mem_waddr = cmd.load ? base_loaded[IW-1:0] : ord_rd_r;
  assign mem_wdata = cmd.load ? {1'b0, w_in} : {1'b1, ent_w};

  always_comb begin
    status.draw_ok  = closed_r && (draw_r < ss_r);
    status.i_last   = (i_r + CW'(1)) == loaded_r;
    status.j_last   = (j_r + CW'(1)) == loaded_r;
    status.mul_last = m_r == MW'(UNIF_W - 1);
    status.walk_end = k_r >= loaded_r;
    status.hit      = hit;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    ent_rd_r <= entry_mem[ent_addr];
    if (cmd.sort_wr) begin
      order_mem[rank_r[IW-1:0]] <= i_r[IW-1:0];
    end
    if (cmd.walk_rd_ord) begin
      ord_rd_r <= order_mem[k_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      draw_r   <= '0;
      total_r  <= '0;
      closed_r <= 1'b0;
      ss_r     <= '0;
    end else begin
      if (cfg_we) begin
        ss_r <= cfg_sample_size;
      end
      if (cmd.load) begin
        loaded_r <= room ? base_loaded + CW'(1) : base_loaded;
        total_r  <= room ? base_total + w_in_t : base_total;
        if (closed_r) begin
          draw_r <= '0;
        end
        closed_r <= in_last_weight;
      end
      if (cmd.draw_start) begin
        draw_r <= draw_inc;
      end
      if (cmd.walk_eval && hit) begin
        total_r <= total_r - ent_w_t;
      end
    end
  end

  // sort, multiply and walk working registers
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      i_r <= '0;
    end
    if (cmd.sort_cap_w) begin
      wi_r   <= ent_w;
      j_r    <= '0;
      rank_r <= '0;
    end
    if (cmd.sort_cmp) begin
      j_r <= j_r + CW'(1);
      if (ahead) begin
        rank_r <= rank_r + CW'(1);
      end
    end
    if (cmd.sort_wr) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.draw_start) begin
      acc_r       <= '0;
      u_r         <= in_uniform;
      m_r         <= '0;
      k_r         <= '0;
      res_idx_r   <= '0;
      res_found_r <= 1'b0;
      res_last_r  <= draw_inc == ss_r;
    end
    if (cmd.refuse) begin
      res_idx_r   <= '0;
      res_found_r <= 1'b0;
      res_last_r  <= 1'b0;
    end
    if (cmd.mul_step) begin
      acc_r <= acc_nxt;
      u_r   <= {u_r[UNIF_W-2:0], 1'b0};
      m_r   <= m_r + MW'(1);
      r_r   <= acc_nxt[AW-1:UNIF_W];
    end
    if (cmd.walk_eval) begin
      if (hit) begin
        res_idx_r   <= idx_ext[IDX_W-1:0];
        res_found_r <= 1'b1;
      end else begin
        k_r <= k_r + CW'(1);
        if (!ent_used) begin
          r_r <= r_r - ent_w_t;
        end
      end
    end
    if (cmd.out_load) begin
      out_selected_index <= res_idx_r;
      out_found          <= res_found_r;
      out_last_draw      <= res_last_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/wswr_ctrl.sv =====
`default_nettype none
`include "weighted_sampling_without_replacement_core_macros.svh"
module wswr_ctrl
  import wswr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_mode,
  input  wire logic    in_last_weight,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire, out_free;

  assign in_stall  = state_r != ST_IDLE;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_mode) begin
            state_nxt = in_last_weight ? ST_SORT_I : ST_IDLE;
          end else begin
            state_nxt = status.draw_ok ? ST_MUL : ST_FIN;
          end
        end
      end
      ST_SORT_I:   state_nxt = ST_SORT_W;
      ST_SORT_W:   state_nxt = ST_SORT_J;
      ST_SORT_J:   state_nxt = ST_SORT_C;
      ST_SORT_C:   state_nxt = status.j_last ? ST_SORT_WR : ST_SORT_J;
      ST_SORT_WR:  state_nxt = status.i_last ? ST_IDLE : ST_SORT_I;
      ST_MUL:      state_nxt = status.mul_last ? ST_WALK_ORD : ST_MUL;
      ST_WALK_ORD: state_nxt = status.walk_end ? ST_FIN : ST_WALK_ENT;
      ST_WALK_ENT: state_nxt = ST_WALK_EVAL;
      ST_WALK_EVAL: state_nxt = status.hit ? ST_FIN : ST_WALK_ORD;
      ST_FIN:      state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load       = !in_mode;
          cmd.sort_init  = !in_mode && in_last_weight;
          cmd.draw_start = in_mode && status.draw_ok;
          cmd.refuse     = in_mode && !status.draw_ok;
        end
      end
      ST_SORT_I:    cmd.sort_rd_i   = 1'b1;
      ST_SORT_W:    cmd.sort_cap_w  = 1'b1;
      ST_SORT_J:    cmd.sort_rd_j   = 1'b1;
      ST_SORT_C:    cmd.sort_cmp    = 1'b1;
      ST_SORT_WR:   cmd.sort_wr     = 1'b1;
      ST_MUL:       cmd.mul_step    = 1'b1;
      ST_WALK_ORD:  cmd.walk_rd_ord = !status.walk_end;
      ST_WALK_ENT:  cmd = '0;
      ST_WALK_EVAL: cmd.walk_eval   = 1'b1;
      ST_FIN:       cmd.out_load    = out_free;
      default:      cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WSWR_ASSERT_NEXT(a_load_word, cmd.out_load, out_valid_r, "result word not presented")
  `WSWR_ASSERT_NEXT(a_hit_fin, (state_r == ST_WALK_EVAL) && status.hit, state_r == ST_FIN, "hit did not finish walk")
  `WSWR_ASSERT_SAME(a_fin_busy, (state_r == ST_FIN) && out_valid_r && out_stall, !cmd.out_load, "result overwritten while held")
  `WSWR_ASSERT_NEXT(a_sort_done, (state_r == ST_SORT_WR) && status.i_last, state_r == ST_IDLE, "sort did not end")

endmodule
`default_nettype wire

// ===== src/weighted_sampling_without_replacement_core.sv =====
// Weighted sampling without replacement, one word at a time.
// Load word: stores one weight; the closing load adds a rank sort of the N loaded entries.
// Draw word: shift-add multiply, one uniform bit per step, then a walk of the ordered entries.
// Refused draws skip the multiply and walk; in_stall stays high until a word is finished.
// Reset (rst_n low, synchronous) empties the set, clears totals and counters
// and sample_size; no memory clearing pass is run.
`default_nettype none
module weighted_sampling_without_replacement_core
  import wswr_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_mode,
  input  wire logic [WEIGHT_W-1:0] in_weight,
  input  wire logic [UNIF_W-1:0]   in_uniform,
  input  wire logic                in_last_weight,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [IDX_W-1:0]         out_selected_index,
  output logic                     out_found,
  output logic                     out_last_draw,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [SS_W-1:0]     cfg_sample_size
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  wswr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_last_weight (in_last_weight),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .cmd            (cmd)
  );

  wswr_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_sample_size    (cfg_sample_size),
    .in_weight          (in_weight),
    .in_uniform         (in_uniform),
    .in_last_weight     (in_last_weight),
    .out_selected_index (out_selected_index),
    .out_found          (out_found),
    .out_last_draw      (out_last_draw)
  );

endmodule
`default_nettype wire

// ===== sim/weighted_sampling_without_replacement_core_test.sv =====
`default_nettype none
module weighted_sampling_without_replacement_core_test;
  import wswr_pkg::*;

  localparam int N_ENT = 64;
  localparam int CYCLE_LIMIT = 10000000;

  class draw_scoreboard;
    logic [WEIGHT_W-1:0] wt [N_ENT];
    logic [IDX_W-1:0]    rank [N_ENT];
    bit                  taken [N_ENT];
    logic [21:0]         total;
    int                  n_loaded;
    int                  n_drawn;
    bit                  closed;
    int                  draw_limit;
    logic [IDX_W-1:0]    q_idx [$];
    bit                  q_found [$];
    bit                  q_last [$];
    int                  errors;

    function void clear_state();
      total = 0;
      n_loaded = 0;
      n_drawn = 0;
      closed = 0;
      draw_limit = 0;
      errors = 0;
      foreach (taken[k]) taken[k] = 0;
    endfunction

    function void set_limit(int v);
      draw_limit = v;
    endfunction

    // stable insertion sort, heaviest first
    function void rank_entries();
      int j;
      for (int i = 0; i < n_loaded; i++) begin
        j = i;
        while (j > 0 && wt[rank[j-1]] < wt[i]) begin
          rank[j] = rank[j-1];
          j--;
        end
        rank[j] = i[IDX_W-1:0];
      end
    endfunction

    function void note_word(bit mode, logic [WEIGHT_W-1:0] w, logic [UNIF_W-1:0] u,
                            bit lastw);
      logic [37:0] r;
      logic [IDX_W-1:0] sel;
      bit hit;
      bit ld;
      int e;
      if (!mode) begin
        if (closed) begin
          n_loaded = 0;
          n_drawn = 0;
          total = 0;
          closed = 0;
          foreach (taken[k]) taken[k] = 0;
        end
        if (n_loaded < N_ENT) begin
          wt[n_loaded] = w;
          taken[n_loaded] = 0;
          total += w;
          n_loaded++;
        end
        if (lastw) begin
          rank_entries();
          closed = 1;
        end
        return;
      end
      sel = 0;
      hit = 0;
      ld = 0;
      if (closed && n_drawn < draw_limit) begin
        n_drawn++;
        ld = (n_drawn == draw_limit);
        r = ({16'd0, total} * {22'd0, u}) >> 16;
        for (int i = 0; i < n_loaded; i++) begin
          e = rank[i];
          if (!taken[e]) begin
            if (r <= wt[e]) begin
              taken[e] = 1;
              total -= wt[e];
              sel = e[IDX_W-1:0];
              hit = 1;
              break;
            end
            r -= wt[e];
          end
        end
      end
      q_idx.push_back(sel);
      q_found.push_back(hit);
      q_last.push_back(ld);
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic fnd, logic ld);
      logic [IDX_W-1:0] e_idx;
      bit e_fnd;
      bit e_ld;
      if (q_idx.size() == 0) begin
        $error("unexpected result word: index %0d found %0d", idx, fnd);
        errors++;
        return;
      end
      e_idx = q_idx.pop_front();
      e_fnd = q_found.pop_front();
      e_ld = q_last.pop_front();
      if (idx !== e_idx) begin
        $error("selected_index: expected %0d, got %0d", e_idx, idx);
        errors++;
      end
      if (fnd !== e_fnd) begin
        $error("found: expected %0d, got %0d", e_fnd, fnd);
        errors++;
      end
      if (ld !== e_ld) begin
        $error("last_draw: expected %0d, got %0d", e_ld, ld);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_mode = 0;
  logic [WEIGHT_W-1:0] in_weight = 0;
  logic [UNIF_W-1:0] in_uniform = 0;
  logic in_last_weight = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [IDX_W-1:0] out_selected_index;
  logic out_found;
  logic out_last_draw;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [SS_W-1:0] cfg_sample_size = 0;

  draw_scoreboard sb;
  int cycle_count = 0;
  int gap_left = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  weighted_sampling_without_replacement_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_weight(in_weight), .in_uniform(in_uniform), .in_last_weight(in_last_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_selected_index(out_selected_index), .out_found(out_found),
    .out_last_draw(out_last_draw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_sample_size(cfg_sample_size)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: alternates stall-heavy and free stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_selected_index, out_found, out_last_draw);
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150)
      out_stall <= 0;
    else if (stall_phase < 300)
      out_stall <= ($urandom_range(0, 3) == 0);
    else
      out_stall <= ($urandom_range(0, 1) == 0);
  end

  // one input word; burst gaps taken before raising valid
  // valid is left high on return, so anything that waits drops it first
  task automatic send_word(bit mode, logic [WEIGHT_W-1:0] w, logic [UNIF_W-1:0] u, bit lastw);
    if (gap_left == 0) begin
      if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
    end else begin
      gap_left--;
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_weight <= w;
    in_uniform <= u;
    in_last_weight <= lastw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(mode, w, u, lastw);
  endtask

  task automatic write_size(int v);
    in_valid <= 0;
    while (sb.q_idx.size() != 0) @(posedge clk);
    // a closing load may still be sorting
    repeat (9000) @(posedge clk);
    cfg_valid <= 1;
    cfg_sample_size <= v[SS_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_limit(v);
  endtask

  task automatic load_set(int n, bit heavy);
    logic [WEIGHT_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      w = heavy ? WEIGHT_W'($urandom_range(1, 65535)) : WEIGHT_W'($urandom_range(1, 8));
      send_word(0, w, WEIGHT_W'($urandom), i == n - 1);
    end
  endtask

  int n_sent;
  int n_set;
  int ss;

  initial begin
    sb = new();
    sb.clear_state();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: draw before any set, then extremes
    write_size(3);
    send_word(1, 0, 16'hFFFF, 0);
    send_word(0, 16'hFFFF, 0, 0);
    send_word(0, 16'd1, 0, 0);
    send_word(0, 16'hFFFF, 0, 0);
    send_word(1, 0, 16'h1234, 0);
    send_word(0, 16'd7, 0, 1);
    send_word(1, 0, 16'h0000, 0);
    send_word(1, 0, 16'hFFFF, 0);
    send_word(1, 0, 16'h8000, 0);
    send_word(1, 0, 16'h8000, 0);
    write_size(64);
    send_word(0, 16'd5, 0, 0);
    send_word(0, 16'd5, 0, 1);
    send_word(1, 0, 16'hFFFF, 0);
    send_word(1, 0, 16'hFFFF, 0);
    send_word(1, 0, 16'hFFFF, 0);
    write_size(0);
    send_word(1, 0, 16'h5555, 0);
    // full store plus a dropped weight
    write_size(64);
    load_set(65, 1);
    for (int i = 0; i < 3; i++) send_word(1, 0, UNIF_W'($urandom), 0);

    n_sent = 0;
    while (n_sent < 1500) begin
      ss = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 64 : 0)
                                       : $urandom_range(1, 10);
      write_size(ss);
      n_set = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(1, 12);
      load_set(n_set, $urandom_range(0, 1));
      n_sent += n_set;
      repeat ($urandom_range(0, ss + 3)) begin
        if ($urandom_range(0, 15) == 0)
          send_word(0, WEIGHT_W'($urandom_range(1, 65535)), 0, 0);
        else
          send_word(1, WEIGHT_W'($urandom), UNIF_W'($urandom), $urandom_range(0, 1));
        n_sent++;
      end
    end

    in_valid <= 0;
    while (sb.q_idx.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
